// ===== design/mahs_pkg.sv =====
`timescale 1ns / 1ps

package mahs_pkg;

   localparam int DEFAULT_WINDOW_DEPTH = 16;
   localparam int DEFAULT_SAMPLE_BITS  = 12;

   localparam int ON_LEVEL_RESET  = 1000;
   localparam int OFF_LEVEL_RESET = 1500;

   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ON_LEVEL  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFF_LEVEL = CSR_INDEX_BITS'(1);

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;   // capture sample, read the oldest ring entry
      logic load;     // update ring, total, slot and count; arm the divider
      logic step;     // one restoring division step
      logic finish;   // apply hysteresis and present the result
   } cmd_type;

endpackage

// ===== design/mahs_ctrl.sv =====
`timescale 1ns / 1ps

module mahs_ctrl #(
   parameter int WINDOW_DEPTH = mahs_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = mahs_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mahs_pkg::cmd_type cmd
);
   import mahs_pkg::*;

   localparam int TOTAL_BITS = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
   localparam int STEP_BITS  = $clog2(TOTAL_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(TOTAL_BITS - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + STEP_BITS'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the finished quotient until the output register is free
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/mahs_datapath.sv =====
`timescale 1ns / 1ps

module mahs_datapath #(
   parameter int WINDOW_DEPTH = mahs_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = mahs_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mahs_pkg::cmd_type                   cmd,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   input  logic                                csr_write,
   input  logic [mahs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SAMPLE_BITS-1:0]              csr_data,
   output logic [SAMPLE_BITS-1:0]              rsp_average,
   output logic                                rsp_switch_on
);
   import mahs_pkg::*;

   localparam int SLOT_BITS  = $clog2(WINDOW_DEPTH);
   localparam int FILL_BITS  = $clog2(WINDOW_DEPTH + 1);
   localparam int TOTAL_BITS = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(WINDOW_DEPTH);
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(WINDOW_DEPTH - 1);

   logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0] ring_rdata_ff;

   logic [SAMPLE_BITS-1:0] on_level_ff, on_level_in;
   logic [SAMPLE_BITS-1:0] off_level_ff, off_level_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;
   logic [TOTAL_BITS-1:0]  quot_ff, quot_in;
   logic [FILL_BITS-1:0]   rem_ff, rem_in;
   logic                   switch_ff, switch_in;
   logic [SAMPLE_BITS-1:0] average_ff;

   logic [SAMPLE_BITS-1:0] oldest;
   logic [FILL_BITS:0]     trial;
   logic [FILL_BITS:0]     divisor;
   logic                   fits;
   logic [SAMPLE_BITS-1:0] mean;

   // ring memory: read the entry about to be replaced, overwrite it in the following cycle
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ring_rdata_ff <= ring_mem[slot_ff];
      end
      if (cmd.load) begin
         ring_mem[slot_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (cmd.finish) begin
         average_ff <= mean;
      end
   end

   // entries beyond the fill count were never written and count as zero
   assign oldest = (fill_ff == FILL_FULL) ? ring_rdata_ff : '0;

   assign trial   = {rem_ff, quot_ff[TOTAL_BITS-1]};
   assign divisor = {1'b0, fill_ff};
   assign fits    = (trial >= divisor);
   assign mean    = quot_ff[SAMPLE_BITS-1:0];

   always_comb begin
      on_level_in  = on_level_ff;
      off_level_in = off_level_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ON_LEVEL:  on_level_in  = csr_data;
            CSR_OFF_LEVEL: off_level_in = csr_data;
            default:       ;
         endcase
      end
   end

   always_comb begin
      total_in  = total_ff;
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      switch_in = switch_ff;
      if (cmd.load) begin
         total_in = total_ff - TOTAL_BITS'(oldest) + TOTAL_BITS'(sample_ff);
         slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_BITS'(1);
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + FILL_BITS'(1);
         end
         quot_in = total_in;
         rem_in  = '0;
      end
      if (cmd.step) begin
         // restoring division, one quotient bit per cycle
         rem_in  = fits ? FILL_BITS'(trial - divisor) : trial[FILL_BITS-1:0];
         quot_in = {quot_ff[TOTAL_BITS-2:0], fits};
      end
      if (cmd.finish) begin
         if (mean <= on_level_ff) begin
            switch_in = 1'b1;
         end else if (mean >= off_level_ff) begin
            switch_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_level_ff  <= SAMPLE_BITS'(ON_LEVEL_RESET);
         off_level_ff <= SAMPLE_BITS'(OFF_LEVEL_RESET);
         total_ff     <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         switch_ff    <= 1'b0;
      end else begin
         on_level_ff  <= on_level_in;
         off_level_ff <= off_level_in;
         total_ff     <= total_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         switch_ff    <= switch_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign rsp_average   = average_ff;
   assign rsp_switch_on = switch_ff;

endmodule

// ===== design/moving_average_hysteresis_switch_core.sv =====
`timescale 1ns / 1ps

// Moving-average light switch with hysteresis.
// Input channel req_: one sensor sample per transaction (req_valid/req_ready).
// Output channel rsp_: the truncated mean of the samples in the window and the
// switch state after that mean has been applied (rsp_valid/rsp_ready).
// Configuration: csr_write with csr_index 0 sets the on level, 1 the off level;
// other indexes are ignored. Write only while the block is idle.
// The running total and the quotient are TOTAL_BITS wide,
// where TOTAL_BITS = SAMPLE_BITS + log2(WINDOW_DEPTH) (16 at the defaults).
// The ring entry being replaced is read at acceptance, LOAD then updates the
// running total, DIV runs the bit-serial divider and DONE applies hysteresis.
// One sample is worked on at a time; req_ready is high only between transactions.
// A finished result sits in the output register while the next sample is
// accepted; if the receiver stalls, the next result waits in the divider.
// Reset (synchronous) empties the window, clears the total and switches off;
// the levels return to 1000 and 1500. No clearing pass is needed.
module moving_average_hysteresis_switch_core #(
   parameter int WINDOW_DEPTH = mahs_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = mahs_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [SAMPLE_BITS-1:0]              rsp_average,
   output logic                                rsp_switch_on,
   input  logic                                csr_write,
   input  logic [mahs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SAMPLE_BITS-1:0]              csr_data
);
   import mahs_pkg::*;

   cmd_type cmd;

   mahs_ctrl #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mahs_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_sample    (req_sample),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_average   (rsp_average),
      .rsp_switch_on (rsp_switch_on)
   );

endmodule

// ===== design/mahs_checker.sv =====
`timescale 1ns / 1ps

module mahs_checker #(
   parameter int SAMPLE_BITS = mahs_pkg::DEFAULT_SAMPLE_BITS
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_average,
   input logic                   rsp_switch_on
);
   import mahs_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average) && $stable(rsp_switch_on))
      else $error("stalled result changed or dropped");

   // nothing to deliver straight after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // one sample at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample accepted while busy");

   // the divider cannot produce a result in the cycle after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind moving_average_hysteresis_switch_core mahs_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_mahs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_average   (rsp_average),
   .rsp_switch_on (rsp_switch_on)
);
